@@ sv/tpls_pkg.sv @@
// Shared constants, opcodes and control/status bundles of the pairwise swap search core.
package tpls_pkg;

  localparam int DEF_MAX_VISITS = 32;
  localparam int DEF_COST_WIDTH = 16;

  localparam int CFG_W      = 6;
  localparam int OP_W       = 2;
  localparam int IDX_W      = 5;
  localparam int CITY_W     = 5;
  localparam int VAL_W      = 16;
  localparam int OUT_COST_W = 21;
  localparam int MAT_AW     = 2 * CITY_W;
  localparam int MAT_DEPTH  = 1 << MAT_AW;

  localparam int IN_DATA_W  = 32;
  localparam int IN_PAD_W   = IN_DATA_W - 2 * IDX_W - VAL_W;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - CITY_W - OUT_COST_W;

  localparam logic [CFG_W-1:0] CFG_LEN_RESET = 6'd2;

  typedef enum logic [OP_W-1:0] {
    OP_COST = 2'd0,
    OP_TOUR = 2'd1,
    OP_RUN  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic mat_we;    // load a cost entry from the input beat
    logic tour_we;   // load a tour position from the input beat
    logic rd_en;     // read the tour store at the walk position
    logic swap_en;   // read positions i and j exchanged
    logic clr;       // clear the path accumulator
    logic base_ld;   // take the accumulated cost as the current tour cost
    logic cmt_i;     // write the captured city into position i
    logic cmt_j;     // write the captured city into position j
    logic out_load;  // load the result register
    logic out_last;  // mark the loaded result as the final position
  } cmd_t;

  typedef struct packed {
    logic better;    // trial path cost strictly below current tour cost
    logic out_free;  // result register can take a new beat this cycle
  } status_t;

endpackage

@@ sv/tpls_ctrl.sv @@
// Sequencer: input decode, swap loop indices, walk timing, commit and emit control.
module tpls_ctrl
  import tpls_pkg::*;
#(
  parameter int MAX_VISITS = DEF_MAX_VISITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [OP_W-1:0]               in_opcode,
  input  logic                          cfg_wr_en,
  input  logic [CFG_W-1:0]              cfg_wr_data,
  input  status_t                       status,
  output cmd_t                          cmd,
  output logic [$clog2(MAX_VISITS)-1:0] pos,
  output logic [$clog2(MAX_VISITS)-1:0] swap_i,
  output logic [$clog2(MAX_VISITS)-1:0] swap_j
);

  localparam int PW = $clog2(MAX_VISITS);
  localparam int LW = $clog2(MAX_VISITS + 1);
  localparam int KW = $clog2(MAX_VISITS + 3);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_WALK    = 7'b0000010,
    S_CMT_I   = 7'b0000100,
    S_CMT_J   = 7'b0001000,
    S_NEXT    = 7'b0010000,
    S_EMIT_RD = 7'b0100000,
    S_EMIT_LD = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  len_r, len_nxt;
  logic [LW-1:0]     n_r, n_nxt;
  logic [KW-1:0]     kc_r, kc_nxt;
  logic [PW-1:0]     i_r, i_nxt;
  logic [PW-1:0]     j_r, j_nxt;
  logic              swap_mode_r, swap_mode_nxt;
  logic              imp_r, imp_nxt;
  logic              in_fire;
  logic [LW-1:0]     n_clamp;
  logic [KW-1:0]     n_k;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign n_k       = KW'(n_r);
  assign swap_i    = i_r;
  assign swap_j    = j_r;

  // Clamp the configured length into the supported range
  always_comb begin
    if (len_r < CFG_W'(2)) begin
      n_clamp = LW'(2);
    end else if (32'(len_r) > MAX_VISITS) begin
      n_clamp = LW'(MAX_VISITS);
    end else begin
      n_clamp = LW'(len_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    n_nxt         = n_r;
    kc_nxt        = kc_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    swap_mode_nxt = swap_mode_r;
    imp_nxt       = imp_r;
    cmd           = '0;
    pos           = kc_r[PW-1:0];

    if (cfg_wr_en) begin
      len_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (op_t'(in_opcode))
            OP_COST: cmd.mat_we = 1'b1;
            OP_TOUR: cmd.tour_we = 1'b1;
            OP_RUN: begin
              n_nxt         = n_clamp;
              kc_nxt        = '0;
              swap_mode_nxt = 1'b0;
              state_nxt     = S_WALK;
            end
            OP_NONE: ;
          endcase
        end
      end
      S_WALK: begin
        cmd.swap_en = swap_mode_r;
        cmd.rd_en   = (kc_r < n_k);
        cmd.clr     = (kc_r == '0);
        // Accumulator settles once the last tour read has passed the edge cost read and accumulate stages
        if (kc_r == n_k + KW'(2)) begin
          kc_nxt = '0;
          if (!swap_mode_r) begin
            cmd.base_ld = 1'b1;
            if (n_k < KW'(4)) begin
              state_nxt = S_EMIT_RD;
            end else begin
              i_nxt         = PW'(1);
              j_nxt         = PW'(2);
              imp_nxt       = 1'b0;
              swap_mode_nxt = 1'b1;
            end
          end else if (status.better) begin
            cmd.base_ld = 1'b1;
            imp_nxt     = 1'b1;
            state_nxt   = S_CMT_I;
          end else begin
            state_nxt = S_NEXT;
          end
        end else begin
          kc_nxt = kc_r + KW'(1);
        end
      end
      S_CMT_I: begin
        cmd.cmt_i = 1'b1;
        state_nxt = S_CMT_J;
      end
      S_CMT_J: begin
        cmd.cmt_j = 1'b1;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        kc_nxt    = '0;
        state_nxt = S_WALK;
        if (KW'(j_r) + KW'(2) < n_k) begin
          j_nxt = j_r + PW'(1);
        end else if (KW'(i_r) + KW'(3) < n_k) begin
          i_nxt = i_r + PW'(1);
          j_nxt = i_r + PW'(2);
        end else if (imp_r) begin
          imp_nxt = 1'b0;
          i_nxt   = PW'(1);
          j_nxt   = PW'(2);
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (kc_r + KW'(1) == n_k);
          if (kc_r + KW'(1) == n_k) begin
            kc_nxt    = '0;
            state_nxt = S_IDLE;
          end else begin
            kc_nxt    = kc_r + KW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= CFG_LEN_RESET;
      n_r         <= LW'(2);
      kc_r        <= '0;
      i_r         <= PW'(1);
      j_r         <= PW'(2);
      swap_mode_r <= 1'b0;
      imp_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      n_r         <= n_nxt;
      kc_r        <= kc_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      swap_mode_r <= swap_mode_nxt;
      imp_r       <= imp_nxt;
    end
  end

`ifndef SYNTH
  a_swap_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && swap_mode_r) |->
      (i_r >= PW'(1) && i_r < j_r && KW'(j_r) + KW'(1) < n_k))
    else $error("swap indices out of window");

  a_commit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMT_J) |-> ($past(state_r) == S_CMT_I))
    else $error("second commit write without first");

  a_commit_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMT_I) |->
      $past(state_r == S_WALK && swap_mode_r && status.better))
    else $error("commit without an improving trial");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (n_k >= KW'(2) && n_k <= KW'(MAX_VISITS)))
    else $error("active tour length out of range");
`endif

endmodule

@@ sv/tpls_dp.sv @@
// Datapath: cost matrix and tour store, path cost pipeline, swap capture and result register.
module tpls_dp
  import tpls_pkg::*;
#(
  parameter int MAX_VISITS = DEF_MAX_VISITS,
  parameter int COST_WIDTH = DEF_COST_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  input  logic [$clog2(MAX_VISITS)-1:0] pos,
  input  logic [$clog2(MAX_VISITS)-1:0] swap_i,
  input  logic [$clog2(MAX_VISITS)-1:0] swap_j,
  input  logic [IDX_W-1:0]              row_index,
  input  logic [IDX_W-1:0]              col_index,
  input  logic [VAL_W-1:0]              load_value,
  output status_t                       status,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [CITY_W-1:0]             out_city,
  output logic [OUT_COST_W-1:0]         out_cost,
  output logic                          out_last
);

  localparam int PW   = $clog2(MAX_VISITS);
  localparam int SUMW = COST_WIDTH + $clog2(MAX_VISITS);

  logic [COST_WIDTH-1:0] mat_mem [MAT_DEPTH];
  logic [CITY_W-1:0]     tour_mem [MAX_VISITS];

  logic [COST_WIDTH-1:0]       mat_q;
  logic [CITY_W-1:0]           tour_q;
  logic [CITY_W-1:0]           prev_r;
  logic [CITY_W-1:0]           city_i_r;
  logic [CITY_W-1:0]           city_j_r;
  logic [PW-1:0]               pos1_r;
  logic                        v1_r;
  logic                        v2_r;
  logic [SUMW-1:0]             acc_r;
  logic [SUMW-1:0]             base_r;
  logic                        out_valid_r;
  logic [CITY_W-1:0]           out_city_r;
  logic [OUT_COST_W-1:0]       out_cost_r;
  logic                        out_last_r;

  logic [PW-1:0]               rd_addr;
  logic                        row_ok;
  logic [PW+IDX_W-1:0]         row_ext;
  logic [COST_WIDTH+VAL_W-1:0] val_ext;
  logic [SUMW+OUT_COST_W-1:0]  cost_ext;
  logic                        mat_rd;

  assign row_ok   = (32'(row_index) < MAX_VISITS);
  assign row_ext  = {{PW{1'b0}}, row_index};
  assign val_ext  = {{COST_WIDTH{1'b0}}, load_value};
  assign cost_ext = {{OUT_COST_W{1'b0}}, base_r};
  assign mat_rd   = v1_r && (pos1_r != '0);

  // Trial walk reads positions i and j exchanged
  always_comb begin
    if (cmd.swap_en && pos == swap_i) begin
      rd_addr = swap_j;
    end else if (cmd.swap_en && pos == swap_j) begin
      rd_addr = swap_i;
    end else begin
      rd_addr = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mat_we) begin
      mat_mem[{row_index, col_index}] <= val_ext[COST_WIDTH-1:0];
    end
    if (mat_rd) begin
      mat_q <= mat_mem[{prev_r, tour_q}];
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.tour_we) begin
      if (row_ok) begin
        tour_mem[row_ext[PW-1:0]] <= load_value[CITY_W-1:0];
      end
    end else if (cmd.cmt_i) begin
      tour_mem[swap_i] <= city_i_r;
    end else if (cmd.cmt_j) begin
      tour_mem[swap_j] <= city_j_r;
    end
    if (cmd.rd_en) begin
      tour_q <= tour_mem[rd_addr];
    end
  end

  // Path cost pipeline: tour read, edge cost read, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= mat_rd;
    end
  end

  always_ff @(posedge clk) begin
    pos1_r <= pos;
    if (v1_r) begin
      prev_r <= tour_q;
      // Hold what each swapped slot received for the commit writes
      if (cmd.swap_en && pos1_r == swap_i) begin
        city_i_r <= tour_q;
      end
      if (cmd.swap_en && pos1_r == swap_j) begin
        city_j_r <= tour_q;
      end
    end
    if (cmd.clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + SUMW'(mat_q);
    end
    if (cmd.base_ld) begin
      base_r <= acc_r;
    end
  end

  assign status.better   = (acc_r < base_r);
  assign status.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_city_r <= tour_q;
      out_cost_r <= cost_ext[OUT_COST_W-1:0];
      out_last_r <= cmd.out_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_city   = out_city_r;
  assign out_cost   = out_cost_r;
  assign out_last   = out_last_r;

endmodule

@@ sv/tour_pairwise_swap_local_search_core.sv @@
// Top level of the pairwise swap local search core: ports, beat packing and module wiring.
// Cost and tour load beats are taken one per cycle. A run beat first walks the stored tour
// to get its cost, then tries every swap of positions i < j inside the fixed endpoints,
// each trial re-walking the whole path, and writes back each adopted swap, position i then
// position j; passes of (n-2)(n-3)/2 trials repeat until one adopts nothing. The walk is
// paced by the single read port of the tour store feeding the single read port of the
// 32x32 cost matrix, one edge per cycle. The improved tour then leaves one beat at a time,
// each with the final cost, tlast on the final position. No new beat is taken until the
// last result has been loaded into the output register.
module tour_pairwise_swap_local_search_core
  import tpls_pkg::*;
#(
  parameter int MAX_VISITS = DEF_MAX_VISITS,
  parameter int COST_WIDTH = DEF_COST_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // row_index[4:0], col_index[9:5], load_value[25:10]
  input  logic [OP_W-1:0]       in_tuser,   // opcode[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // city[4:0], tour_cost[25:5]
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data // tour_length[5:0]
);

  localparam int PW = $clog2(MAX_VISITS);

  cmd_t                  cmd;
  status_t               status;
  logic [PW-1:0]         pos;
  logic [PW-1:0]         swap_i;
  logic [PW-1:0]         swap_j;
  logic [CITY_W-1:0]     out_city;
  logic [OUT_COST_W-1:0] out_cost;
  logic                  unused_pad;

  assign unused_pad = ^in_tdata[IN_DATA_W-1:IN_DATA_W-IN_PAD_W];

  tpls_ctrl #(
    .MAX_VISITS(MAX_VISITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_opcode  (in_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .status     (status),
    .cmd        (cmd),
    .pos        (pos),
    .swap_i     (swap_i),
    .swap_j     (swap_j)
  );

  tpls_dp #(
    .MAX_VISITS(MAX_VISITS),
    .COST_WIDTH(COST_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .pos       (pos),
    .swap_i    (swap_i),
    .swap_j    (swap_j),
    .row_index (in_tdata[IDX_W-1:0]),
    .col_index (in_tdata[2*IDX_W-1:IDX_W]),
    .load_value(in_tdata[2*IDX_W+VAL_W-1:2*IDX_W]),
    .status    (status),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_city  (out_city),
    .out_cost  (out_cost),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{OUT_PAD_W{unused_pad & 1'b0}}, out_cost, out_city};

endmodule
